// ----- hw/rtl/asset_path_stepper_macros.svh -----
// Assertion macros shared by the asset path stepper modules.
`ifndef ASSET_PATH_STEPPER_MACROS_SVH
`define ASSET_PATH_STEPPER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hw/rtl/aps_pkg.sv -----
// Package with types, constants and arithmetic helpers of the asset path stepper.
`default_nettype none
package aps_pkg;
	localparam int NUM_DIMS_DEF = 3;
	localparam logic signed [31:0] MIX_A = 32'sd19661;
	localparam logic signed [31:0] MIX_B = 32'sd62517;
	localparam logic signed [31:0] MIX_C = 32'sd14427;
	localparam logic signed [31:0] MIX_D = 32'sd60830;
	localparam logic signed [31:0] LN2_Q = 32'sd45426;
	localparam logic [2:0] CFG_MODEL = 3'd0;
	localparam logic [2:0] CFG_DRIFT = 3'd1;
	localparam logic [2:0] CFG_STEP_TIME = 3'd2;
	localparam logic [2:0] CFG_VOL_0 = 3'd3;
	localparam logic [2:0] CFG_VOL_1 = 3'd4;
	localparam logic [2:0] CFG_VOL_2 = 3'd5;
	localparam logic [2:0] CFG_REV_RATE = 3'd6;
	localparam logic [2:0] CFG_LEVEL = 3'd7;

	typedef enum logic [1:0] {
		MODEL_LOGN = 2'd0,
		MODEL_EULER = 2'd1,
		MODEL_SQRT = 2'd2,
		MODEL_CORR = 2'd3
	} model_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_EXP_DIV, ST_EXP_TERM, ST_SQRT, ST_NEXT, ST_DONE
	} state_t;

	typedef struct packed {
		logic action;
		logic signed [31:0] w0;
		logic signed [31:0] z1;
		logic signed [31:0] z2;
		logic signed [31:0] w1;
		logic signed [31:0] w2;
	} job_t;

	typedef struct packed {
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Arithmetic shift of the full product floors toward minus infinity.
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b;
		return sat32(66'(p >>> 16));
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) + 66'(b));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(66'(a) - 66'(b));
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/aps_front.sv -----
// Front end: accepts items, forms the mixed increments and queues the job.
`default_nettype none
`include "asset_path_stepper_macros.svh"
module aps_front import aps_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_action,
	input wire logic signed [31:0] in_a,
	input wire logic signed [31:0] in_b,
	input wire logic signed [31:0] in_c,
	output logic job_valid,
	input wire logic job_ready,
	output job_t job
);
	job_t q_mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	job_t nj;
	logic push, pop;

	// Mixing products are combinational; the summed increments are registered in the queue entry: one product layer.
	always_comb begin
		nj.action = in_action;
		nj.w0 = in_a;
		nj.w1 = in_b;
		nj.w2 = in_c;
		nj.z1 = qadd(qmul(MIX_A, in_a), qmul(MIX_B, in_b));
		nj.z2 = qadd(qadd(qmul(MIX_A, in_a), qmul(MIX_C, in_b)), qmul(MIX_D, in_c));
	end

	assign in_ready = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`APS_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`APS_ASSERT_NEXT(a_fill, clk, arst_n, push && !pop, cnt_q != 2'd0)
	`APS_ASSERT_NEXT(a_drain, clk, arst_n, pop && !push && cnt_q == 2'd1, !job_valid)
endmodule
`default_nettype wire

// ----- hw/rtl/aps_back.sv -----
// Back end: steps each dimension through a sequencer with shared iterative units.
`default_nettype none
`include "asset_path_stepper_macros.svh"
module aps_back import aps_pkg::*; #(
	parameter int NUM_DIMS = NUM_DIMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [1:0] model,
	input wire logic signed [31:0] drift,
	input wire logic [30:0] step_time,
	input wire logic [30:0] vol_0,
	input wire logic [30:0] vol_1,
	input wire logic [30:0] vol_2,
	input wire logic [30:0] reversion_rate,
	input wire logic [30:0] long_run_level,
	input wire logic job_valid,
	output logic job_ready,
	input wire job_t job,
	output logic res_valid,
	input wire logic res_ready,
	output res_t res
);
	state_t state_q, state_d;
	job_t job_q;
	logic signed [31:0] price_q [3];
	logic [1:0] dim_q;
	logic [2:0] ph_q;
	logic signed [31:0] t1_q, t2_q, t3_q;
	// exponent split
	logic signed [31:0] rem_q;
	logic signed [5:0] k_q;
	logic [3:0] it_q;
	logic hf_q;
	logic [63:0] sum_q;
	logic [30:0] term_q;
	logic [29:0] x_q;
	logic [29:0] tm_q;
	logic [63:0] sv_q, sres_q, sbit_q;
	logic [5:0] sit_q;
	logic res_valid_q;
	logic signed [31:0] p, vol, wd, zd, np;
	logic [29:0] tmul;
	logic [30:0] rm;
	logic [5:0] rs;
	logic [30:0] quo;
	logic last_dim;

	always_comb begin
		p = price_q[dim_q];
		unique case (dim_q)
			2'd0: begin vol = {1'b0, vol_0}; wd = job_q.w0; zd = job_q.w0; end
			2'd1: begin vol = {1'b0, vol_1}; wd = job_q.w1; zd = job_q.z1; end
			default: begin vol = {1'b0, vol_2}; wd = job_q.w2; zd = job_q.z2; end
		endcase
		// The term stays at or below 2^30 and x below 2^30, so the product fits 61 bits.
		tmul = 30'((61'(term_q) * 61'(x_q)) >> 30);
		last_dim = (32'(dim_q) == NUM_DIMS - 1);
	end

	// Division of a term below 2^30 by the series index, as an exact reciprocal multiply.
	always_comb begin
		unique case (it_q)
			4'd3: begin rm = 31'd1431655766; rs = 6'd32; end
			4'd4: begin rm = 31'd1073741824; rs = 6'd32; end
			4'd5: begin rm = 31'd1717986919; rs = 6'd33; end
			4'd6: begin rm = 31'd1431655766; rs = 6'd33; end
			4'd7: begin rm = 31'd1227133514; rs = 6'd33; end
			4'd8: begin rm = 31'd1073741824; rs = 6'd33; end
			4'd9: begin rm = 31'd1908874354; rs = 6'd34; end
			4'd10: begin rm = 31'd1717986919; rs = 6'd34; end
			4'd11: begin rm = 31'd1561806290; rs = 6'd34; end
			4'd12: begin rm = 31'd1431655766; rs = 6'd34; end
			4'd2: begin rm = 31'd1073741824; rs = 6'd31; end
			default: begin rm = 31'd1073741824; rs = 6'd30; end
		endcase
		quo = 31'((61'(tm_q) * 61'(rm)) >> rs);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (job_valid && !res_valid_q) state_d = ST_MUL;
			ST_MUL: begin
				if (!job_q.action) state_d = ST_NEXT;
				else if (model == MODEL_EULER && ph_q == 3'd2) state_d = ST_NEXT;
				else if (model == MODEL_SQRT && ph_q == 3'd0) state_d = ST_SQRT;
				else if (model == MODEL_SQRT && ph_q == 3'd4) state_d = ST_NEXT;
				else if ((model == MODEL_LOGN || model == MODEL_CORR) && ph_q == 3'd2)
					state_d = ST_EXP_DIV;
				else if ((model == MODEL_LOGN || model == MODEL_CORR) && ph_q == 3'd4)
					state_d = ST_NEXT;
			end
			ST_EXP_DIV: if (rem_q >= 0 && rem_q < LN2_Q) state_d = ST_EXP_TERM;
			ST_EXP_TERM: if (it_q == 4'd12 && hf_q) state_d = ST_MUL;
			ST_SQRT: if (sit_q == 6'd32) state_d = ST_MUL;
			ST_NEXT: state_d = last_dim ? ST_DONE : ST_MUL;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	assign job_ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res.p0 = price_q[0];
	assign res.p1 = price_q[1];
	assign res.p2 = price_q[2];

	always_comb begin
		np = t1_q;
		if (job_q.action && model == MODEL_SQRT && t1_q < 0) np = '0;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
			end
			ST_MUL: begin
				if (!job_q.action) t1_q <= wd;
				else unique case (model)
					MODEL_EULER: unique case (ph_q)
						3'd0: t2_q <= qmul(drift, p);
						3'd1: begin
							t1_q <= qadd(p, qmul(t2_q, {1'b0, step_time}));
							t2_q <= qmul(vol, p);
						end
						default: t1_q <= qadd(t1_q, qmul(t2_q, wd));
					endcase
					MODEL_SQRT: unique case (ph_q)
						3'd0: begin
							sv_q <= (p <= 0) ? 64'd0 : {16'd0, p, 16'd0};
							sres_q <= '0;
							sbit_q <= 64'd1 << 62;
						end
						3'd1: t2_q <= qmul({1'b0, reversion_rate},
							qsub({1'b0, long_run_level}, p));
						3'd2: begin
							t1_q <= qadd(p, qmul(t2_q, {1'b0, step_time}));
							t2_q <= qmul(vol, sres_q[31:0]);
						end
						3'd3: t1_q <= qadd(t1_q, qmul(t2_q, wd));
						default: ;
					endcase
					default: unique case (ph_q)
						3'd0: t2_q <= qmul(vol, vol) >>> 1;
						3'd1: begin
							t2_q <= qmul(qsub(drift, t2_q), {1'b0, step_time});
							t3_q <= qmul(vol, (model == MODEL_CORR) ? zd : wd);
						end
						3'd2: begin
							rem_q <= qadd(t2_q, t3_q);
							k_q <= '0;
						end
						3'd3: begin
							if (k_q >= 6'sd15) t2_q <= 32'sh7FFFFFFF;
							else if (k_q < -6'sd17) t2_q <= '0;
							else t2_q <= 32'(sum_q >> (6'sd14 - k_q));
						end
						default: t1_q <= qmul(p, t2_q);
					endcase
				endcase
			end
			ST_EXP_DIV: begin
				// One subtract or add of ln 2 per cycle; clamp once the exponent is out of range.
				if (rem_q >= LN2_Q && k_q < 6'sd15) begin
					rem_q <= rem_q - LN2_Q; k_q <= k_q + 6'sd1;
				end else if (rem_q < 0 && k_q > -6'sd18) begin
					rem_q <= rem_q + LN2_Q; k_q <= k_q - 6'sd1;
				end else if (rem_q < 0 || rem_q >= LN2_Q) begin
					rem_q <= '0;
				end
				sum_q <= 64'd1 << 30;
				term_q <= 31'd1 << 30;
				x_q <= {rem_q[15:0], 14'd0};
				it_q <= 4'd0;
				hf_q <= 1'b0;
			end
			ST_EXP_TERM: begin
				// Each term is formed as the product with x, then the division.
				if (it_q == 4'd0) begin
					x_q <= {rem_q[15:0], 14'd0};
					it_q <= 4'd1;
				end else if (!hf_q) begin
					tm_q <= tmul;
					hf_q <= 1'b1;
				end else begin
					term_q <= quo;
					sum_q <= sum_q + 64'(quo);
					it_q <= it_q + 4'd1;
					hf_q <= 1'b0;
				end
			end
			ST_SQRT: begin
				if (sbit_q != 0) begin
					if (sv_q >= sres_q + sbit_q) begin
						sv_q <= sv_q - (sres_q + sbit_q);
						sres_q <= (sres_q >> 1) + sbit_q;
					end else sres_q <= sres_q >> 1;
					sbit_q <= sbit_q >> 2;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q <= '0;
			ph_q <= '0;
			sit_q <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) price_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin dim_q <= '0; ph_q <= '0; end
				ST_MUL: begin ph_q <= ph_q + 3'd1; sit_q <= '0; end
				ST_NEXT: begin
					price_q[dim_q] <= np;
					dim_q <= dim_q + 2'd1;
					ph_q <= '0;
				end
				ST_DONE: res_valid_q <= 1'b1;
				ST_SQRT: sit_q <= sit_q + 6'd1;
				default: ;
			endcase
		end
	end

	`APS_ASSERT_IMP(a_ready_idle, clk, arst_n, job_ready, state_q == ST_IDLE)
	`APS_ASSERT_NEXT(a_done_res, clk, arst_n, state_q == ST_DONE, res_valid)
	`APS_ASSERT_IMP(a_dim_range, clk, arst_n, state_q != ST_IDLE && state_q != ST_DONE, 32'(dim_q) < NUM_DIMS)
endmodule
`default_nettype wire

// ----- hw/rtl/asset_path_stepper.sv -----
// Top level of the asset path stepper: registers, front end and back end.
// Channel | Signals                                   | Direction
// in      | in_valid/in_ready, action, value_a..c     | into block
// out     | out_valid/out_ready, price_0..2, nonpos.  | out of block
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | into block
// An item is taken in the idle state and finished in the done state; per dimension the
// sequencer runs a load, an Euler step, the square root model (with its bit-serial root)
// or lognormal (with the iterative ln 2 split and the 12-term series unit).
// Reset clears prices and registers; a two-entry queue lets input continue while
// the result waits, and out_ready low holds the result and stops new work.
`default_nettype none
module asset_path_stepper import aps_pkg::*; #(
	parameter int NUM_DIMS = NUM_DIMS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic action,
	input wire logic signed [31:0] value_a,
	input wire logic signed [31:0] value_b,
	input wire logic signed [31:0] value_c,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [31:0] price_0,
	output logic signed [31:0] price_1,
	output logic signed [31:0] price_2,
	output logic nonpositive,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	logic [1:0] model_q;
	logic signed [31:0] drift_q;
	logic [30:0] step_q, v0_q, v1_q, v2_q, rr_q, lvl_q;
	logic job_valid, job_ready;
	job_t job;
	res_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q <= '0; drift_q <= '0; step_q <= '0; v0_q <= '0;
			v1_q <= '0; v2_q <= '0; rr_q <= '0; lvl_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MODEL: model_q <= cfg_data[1:0];
				CFG_DRIFT: drift_q <= cfg_data;
				CFG_STEP_TIME: step_q <= cfg_data[30:0];
				CFG_VOL_0: v0_q <= cfg_data[30:0];
				CFG_VOL_1: v1_q <= cfg_data[30:0];
				CFG_VOL_2: v2_q <= cfg_data[30:0];
				CFG_REV_RATE: rr_q <= cfg_data[30:0];
				CFG_LEVEL: lvl_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	aps_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_action(action),
		.in_a(value_a), .in_b(value_b), .in_c(value_c),
		.job_valid, .job_ready, .job
	);

	aps_back #(.NUM_DIMS(NUM_DIMS)) u_back (
		.clk, .arst_n, .model(model_q), .drift(drift_q), .step_time(step_q),
		.vol_0(v0_q), .vol_1(v1_q), .vol_2(v2_q), .reversion_rate(rr_q),
		.long_run_level(lvl_q), .job_valid, .job_ready, .job,
		.res_valid(out_valid), .res_ready(out_ready), .res
	);

	assign price_0 = res.p0;
	assign price_1 = res.p1;
	assign price_2 = res.p2;
	assign nonpositive = (res.p0 <= 0);
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench of the asset path stepper with a bit-exact price predictor.
`timescale 1ns / 1ps
module testbench;
	import aps_pkg::*;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_STEP = 1'b1;
	localparam int DIMS = NUM_DIMS_DEF;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASES = 10;
	localparam int SETTLE_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic action;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
	} path_item_t;

	typedef struct {
		logic signed [31:0] p0;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
		logic np;
	} path_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_LOAD;
	logic signed [31:0] value_a = '0;
	logic signed [31:0] value_b = '0;
	logic signed [31:0] value_c = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] price_0;
	logic signed [31:0] price_1;
	logic signed [31:0] price_2;
	logic nonpositive;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = CFG_MODEL;
	logic [31:0] cfg_data = '0;

	asset_path_stepper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.value_a(value_a), .value_b(value_b), .value_c(value_c),
		.out_valid(out_valid), .out_ready(out_ready),
		.price_0(price_0), .price_1(price_1), .price_2(price_2),
		.nonpositive(nonpositive),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the registers and the path state.
	model_t cur_model = MODEL_LOGN;
	longint cur_drift = 0;
	longint cur_dt = 0;
	longint cur_vol[3] = '{0, 0, 0};
	longint cur_rate = 0;
	longint cur_level = 0;
	longint path_prices[3] = '{0, 0, 0};

	path_item_t pending_items[$];
	path_result_t expected_prices[$];
	int errors = 0;
	int accepted_items = 0;
	longint cycles = 0;
	bit in_fire = 1'b0;

	function automatic longint fx_sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		longint p;
		p = a * b;
		return fx_sat(p >>> 16);
	endfunction

	function automatic longint fx_exp(longint e);
		longint k, r, sh, ln2;
		longint unsigned x, sum, term;
		ln2 = longint'(LN2_Q);
		if (e >= 0) k = e / ln2;
		else k = -((-e + ln2 - 1) / ln2);
		r = e - k * ln2;
		if (k >= 15) return 64'sd2147483647;
		x = longint'(r) << 14;
		sum = 64'd1 << 30;
		term = sum;
		for (int i = 1; i <= 12; i++) begin
			term = ((term * x) >> 30) / i;
			sum += term;
		end
		sh = 14 - k;
		if (sh >= 32) return 0;
		return longint'(sum >> sh);
	endfunction

	function automatic longint fx_sqrt(longint xq);
		longint unsigned v, res, bitv;
		if (xq <= 0) return 0;
		res = 0;
		bitv = 64'd1 << 62;
		v = longint'(xq) << 16;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint lognormal_price(longint p, longint vol, longint z);
		longint half, e;
		half = fx_mul(vol, vol) >>> 1;
		e = fx_sat(fx_mul(fx_sat(cur_drift - half), cur_dt) + fx_mul(vol, z));
		return fx_mul(p, fx_exp(e));
	endfunction

	function automatic path_result_t advance_path(path_item_t it);
		longint w[3], z[3];
		longint p, vol, n;
		path_result_t res;
		w[0] = longint'(it.a);
		w[1] = longint'(it.b);
		w[2] = longint'(it.c);
		z[0] = w[0];
		z[1] = fx_sat(fx_mul(MIX_A, w[0]) + fx_mul(MIX_B, w[1]));
		z[2] = fx_sat(fx_sat(fx_mul(MIX_A, w[0]) + fx_mul(MIX_C, w[1])) + fx_mul(MIX_D, w[2]));
		for (int d = 0; d < DIMS; d++) begin
			p = path_prices[d];
			vol = cur_vol[d];
			if (it.action == ACT_LOAD) begin
				n = w[d];
			end else if (cur_model == MODEL_LOGN) begin
				n = lognormal_price(p, vol, w[d]);
			end else if (cur_model == MODEL_EULER) begin
				n = fx_sat(p + fx_mul(fx_mul(cur_drift, p), cur_dt));
				n = fx_sat(n + fx_mul(fx_mul(vol, p), w[d]));
			end else if (cur_model == MODEL_SQRT) begin
				n = fx_sat(p + fx_mul(fx_mul(cur_rate, fx_sat(cur_level - p)), cur_dt));
				n = fx_sat(n + fx_mul(fx_mul(vol, fx_sqrt(p)), w[d]));
				if (n < 0) n = 0;
			end else begin
				n = lognormal_price(p, vol, z[d]);
			end
			path_prices[d] = n;
		end
		res.p0 = path_prices[0][31:0];
		res.p1 = path_prices[1][31:0];
		res.p2 = path_prices[2][31:0];
		res.np = (path_prices[0] <= 0);
		return res;
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [31:0] data);
		longint u;
		u = longint'({1'b0, data[30:0]});
		case (idx)
			CFG_MODEL: cur_model = model_t'(data[1:0]);
			CFG_DRIFT: cur_drift = longint'($signed(data));
			CFG_STEP_TIME: cur_dt = u;
			CFG_VOL_0: cur_vol[0] = u;
			CFG_VOL_1: cur_vol[1] = u;
			CFG_VOL_2: cur_vol[2] = u;
			CFG_REV_RATE: cur_rate = u;
			CFG_LEVEL: cur_level = u;
			default: ;
		endcase
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Input acceptance: the predictor runs on every accepted item.
	always @(posedge clk) begin
		in_fire = in_valid && in_ready;
		if (in_fire) begin
			expected_prices.push_back(advance_path(pending_items.pop_front()));
			accepted_items++;
		end
	end

	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (in_valid && !in_fire) begin
			// The item is held until it is taken.
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_items.size() > 0) begin
			action <= pending_items[0].action;
			value_a <= pending_items[0].a;
			value_b <= pending_items[0].b;
			value_c <= pending_items[0].c;
			in_valid <= 1'b1;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: segments of always-ready, random and periodic stalls, plus one long hold.
	int seg_left = 0;
	int seg_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (!hold_done && accepted_items >= 300) begin
			hold_done = 1'b1;
			hold_left = 600;
		end
		if (seg_left == 0) begin
			seg_left = $urandom_range(10, 80);
			seg_mode = $urandom_range(0, 3);
		end else begin
			seg_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (seg_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				2: out_ready <= (cycles % 5 != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		path_result_t e;
		if (out_valid && out_ready) begin
			if (expected_prices.size() == 0) begin
				$error("result with no item waiting");
				errors++;
			end else begin
				e = expected_prices.pop_front();
				if (price_0 !== e.p0) begin
					$error("price_0 expected %h actual %h", e.p0, price_0); errors++;
				end
				if (price_1 !== e.p1) begin
					$error("price_1 expected %h actual %h", e.p1, price_1); errors++;
				end
				if (price_2 !== e.p2) begin
					$error("price_2 expected %h actual %h", e.p2, price_2); errors++;
				end
				if (nonpositive !== e.np) begin
					$error("nonpositive expected %b actual %b", e.np, nonpositive); errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] regs[8]);
		write_reg(CFG_MODEL, regs[0]);
		write_reg(CFG_DRIFT, regs[1]);
		write_reg(CFG_STEP_TIME, regs[2]);
		write_reg(CFG_VOL_0, regs[3]);
		write_reg(CFG_VOL_1, regs[4]);
		write_reg(CFG_VOL_2, regs[5]);
		write_reg(CFG_REV_RATE, regs[6]);
		write_reg(CFG_LEVEL, regs[7]);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || expected_prices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void queue_item(logic act, logic [31:0] a, logic [31:0] b,
		logic [31:0] c);
		path_item_t it;
		it.action = act;
		it.a = a;
		it.b = b;
		it.c = c;
		pending_items.push_back(it);
	endfunction

	function automatic logic [31:0] rand_increment();
		if ($urandom_range(0, 19) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 196608)) - 98304);
	endfunction

	function automatic logic [31:0] rand_price();
		if ($urandom_range(0, 19) == 0) return $urandom;
		return $urandom_range(1, 32'd500 << 16);
	endfunction

	initial begin
		logic [31:0] regs[8];
		int kind;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A step before any load works on the zero prices left by reset.
		queue_item(ACT_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
		drain();

		// Directed: each model with ordinary values, then the extremes.
		for (int m = 0; m < 4; m++) begin
			regs = '{32'(m), 32'h0000_0CCD, 32'h0000_0148, 32'h0000_3333, 32'h0000_4CCD,
				32'h0000_199A, 32'h0001_8000, 32'h0064_0000};
			write_all(regs);
			queue_item(ACT_LOAD, 32'h0064_0000, 32'h0032_0000, 32'h0001_0000);
			queue_item(ACT_STEP, 32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000);
			queue_item(ACT_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
			if (m == 2) begin
				// A negative price under the square root.
				queue_item(ACT_LOAD, 32'hFFF0_0000, 32'h8000_0000, 32'h0000_0000);
				queue_item(ACT_STEP, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
			end
			drain();
		end
		// Huge volatility makes the exponent overflow one way or the other.
		regs = '{MODEL_CORR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
		write_all(regs);
		queue_item(ACT_LOAD, 32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000);
		queue_item(ACT_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_item(ACT_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		queue_item(ACT_STEP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();
		regs = '{MODEL_EULER, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
		write_all(regs);
		queue_item(ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		queue_item(ACT_STEP, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			kind = ph % 5;
			regs[0] = $urandom;
			if (kind == 3) begin
				for (int r = 1; r < 8; r++) regs[r] = $urandom;
			end else if (kind == 4) begin
				regs = '{regs[0], 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
					32'h0, 32'h7FFF_FFFF, 32'h0};
			end else begin
				regs[1] = 32'($signed($urandom_range(0, 16384)) - 8192);
				regs[2] = $urandom_range(0, 2048);
				regs[3] = $urandom_range(0, 40000);
				regs[4] = $urandom_range(0, 40000);
				regs[5] = $urandom_range(0, 40000);
				regs[6] = $urandom_range(0, 200000);
				regs[7] = $urandom_range(0, 32'd200 << 16);
			end
			write_all(regs);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if ($urandom_range(0, 6) == 0)
					queue_item(ACT_LOAD, rand_price(), rand_price(), rand_price());
				else
					queue_item(ACT_STEP, rand_increment(), rand_increment(),
						rand_increment());
			end
			drain();
		end

		if (expected_prices.size() != 0) begin
			$error("items left without a result");
			errors++;
		end
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
